// ===== hw/rtl/tbps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the token bucket packet shaper.
// Depends on nothing; every other file of the shaper imports it.
package tbps_pkg;

   // Packet queue geometry.
   localparam int unsigned QUEUE_DEPTH = 16;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Field widths.
   localparam int unsigned ID_W   = 16;
   localparam int unsigned TOK_W  = 16;

   // Command queue between the front and the back.
   localparam int unsigned CMDQ_DEPTH = 2;
   localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
   localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

   // Operation codes.
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_ARRIVE = 1'b1;

   // Register map.
   localparam int unsigned CSR_ADDR_W      = 3;
   localparam logic        CSR_IDX_DEPTH   = 1'b0;
   localparam logic [TOK_W-1:0] DEPTH_RESET = 16'd10;

   // One classified command waiting for the back.
   typedef struct packed {
      logic             arrive;
      logic [ID_W-1:0]  packet_id;
      logic [TOK_W-1:0] tokens_needed;
   } cmd_type;

   // Front to back link.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

endpackage

// ===== hw/rtl/token_bucket_packet_shaper_core.sv =====
`timescale 1ns / 1ps
// Top level of the token bucket packet shaper: register port, front and back.
// Depends on tbps_pkg, tbps_front and tbps_back.
//
// Channel   Handshake              Ports
// request   start high, busy low   req_operation, req_packet_id, req_tokens_needed
// response  rsp_strobe, one cycle  rsp_token_dropped .. rsp_queue_count
// register  psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// A request that is taken waits in the command queue; the back then updates
// the bucket and packet queue and registers the result, marked by rsp_strobe.
// One request per cycle is sustained; the back finishes a command every cycle.
// busy rises only if the two entry command queue fills, which a steady flow of
// one request per cycle does not cause. Results cannot be stalled.
// Reset is synchronous and clears queues and bucket; bucket_depth returns to 10.
module token_bucket_packet_shaper_core import tbps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_operation,
   input  logic [ID_W-1:0]       req_packet_id,
   input  logic [TOK_W-1:0]      req_tokens_needed,
   output logic                  rsp_strobe,
   output logic                  rsp_token_dropped,
   output logic                  rsp_packet_released,
   output logic [ID_W-1:0]       rsp_released_id,
   output logic                  rsp_packet_refused,
   output logic [TOK_W-1:0]      rsp_bucket_level,
   output logic [QCNT_W-1:0]     rsp_queue_count,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [TOK_W-1:0] depth_ff, depth_in;
   logic             csr_write;
   cmd_link_type     cmd_link;

   // Register port: always ready, register index from the word address.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      depth_in = depth_ff;
      if (csr_write && (paddr[2] == CSR_IDX_DEPTH)) begin
         depth_in = pwdata[TOK_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_IDX_DEPTH) begin
         prdata = {{(32-TOK_W){1'b0}}, depth_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
      end else begin
         depth_ff <= depth_in;
      end
   end

   tbps_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_operation     (req_operation),
      .req_packet_id     (req_packet_id),
      .req_tokens_needed (req_tokens_needed),
      .cmd_link          (cmd_link)
   );

   tbps_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cmd_link            (cmd_link),
      .bucket_depth        (depth_ff),
      .rsp_strobe          (rsp_strobe),
      .rsp_token_dropped   (rsp_token_dropped),
      .rsp_packet_released (rsp_packet_released),
      .rsp_released_id     (rsp_released_id),
      .rsp_packet_refused  (rsp_packet_refused),
      .rsp_bucket_level    (rsp_bucket_level),
      .rsp_queue_count     (rsp_queue_count)
   );

endmodule

// ===== hw/rtl/tbps_front.sv =====
`timescale 1ns / 1ps
// Front part of the shaper: takes start transfers, classifies them and
// holds them in a short command queue. Depends on tbps_pkg.
module tbps_front import tbps_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_operation,
   input  logic [ID_W-1:0]  req_packet_id,
   input  logic [TOK_W-1:0] req_tokens_needed,
   output cmd_link_type     cmd_link
);

   cmd_type               q_ff [CMDQ_DEPTH];
   logic [CMDQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CMDQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CMDQ_CNT_W-1:0] count_ff, count_in;
   logic                  push;
   logic                  pop;
   cmd_type               new_cmd;

   // The queue refuses new transfers only when it is full.
   assign busy = (count_ff == CMDQ_CNT_W'(CMDQ_DEPTH));
   assign push = start && !busy;
   assign pop  = (count_ff != '0);

   // Classify the incoming item; fields that mean nothing on a tick are cleared.
   always_comb begin
      new_cmd.arrive        = (req_operation == OP_ARRIVE);
      new_cmd.packet_id     = new_cmd.arrive ? req_packet_id : '0;
      new_cmd.tokens_needed = new_cmd.arrive ? req_tokens_needed : '0;
   end

   // The back takes the head command in every cycle that one is present.
   assign cmd_link.valid = pop;
   assign cmd_link.cmd   = q_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Command storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   // Occupancy never exceeds the queue depth.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CMDQ_CNT_W'(CMDQ_DEPTH))
      else $error("command queue overfilled");

   // A transfer taken while nothing drains raises the occupancy by one.
   a_cnt_push: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("command queue count did not follow a push");

   // The pointers stay consistent with the occupancy.
   a_ptr_cnt: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("command queue pointers differ while empty");

endmodule

// ===== hw/rtl/tbps_back.sv =====
`timescale 1ns / 1ps
// Back part of the shaper: token bucket, packet queue and result register.
// Depends on tbps_pkg; takes one command per cycle from tbps_front.
module tbps_back import tbps_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cmd_link_type      cmd_link,
   input  logic [TOK_W-1:0]  bucket_depth,
   output logic              rsp_strobe,
   output logic              rsp_token_dropped,
   output logic              rsp_packet_released,
   output logic [ID_W-1:0]   rsp_released_id,
   output logic              rsp_packet_refused,
   output logic [TOK_W-1:0]  rsp_bucket_level,
   output logic [QCNT_W-1:0] rsp_queue_count
);

   // Packet store: id in the upper half, token need in the lower half.
   logic [ID_W+TOK_W-1:0] store_ff [QUEUE_DEPTH];

   logic [TOK_W-1:0]  level_ff, level_in;
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   logic              strobe_ff;
   logic              dropped_ff, dropped_in;
   logic              released_ff, released_in;
   logic [ID_W-1:0]   rel_id_ff, rel_id_in;
   logic              refused_ff, refused_in;

   logic [TOK_W:0]    level_plus;
   logic [TOK_W-1:0]  level_tick;
   logic [TOK_W-1:0]  head_need;
   logic [ID_W-1:0]   head_id;
   logic              write_en;

   assign head_need = store_ff[head_ff][TOK_W-1:0];
   assign head_id   = store_ff[head_ff][ID_W+TOK_W-1:TOK_W];

   // Bucket and queue update for one command.
   always_comb begin
      level_in    = level_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      count_in    = count_ff;
      dropped_in  = 1'b0;
      released_in = 1'b0;
      rel_id_in   = '0;
      refused_in  = 1'b0;
      write_en    = 1'b0;
      level_plus  = {1'b0, level_ff} + 1'b1;
      level_tick  = level_ff;
      if (cmd_link.valid) begin
         if (!cmd_link.cmd.arrive) begin
            // Add the token unless it takes the bucket above its depth.
            if (level_plus > {1'b0, bucket_depth}) begin
               dropped_in = 1'b1;
               level_tick = level_ff;
            end else begin
               level_tick = level_plus[TOK_W-1:0];
            end
            level_in = level_tick;
            // Release the head packet when the bucket covers its need.
            if ((count_ff != '0) && (head_need <= level_tick)) begin
               level_in    = level_tick - head_need;
               released_in = 1'b1;
               rel_id_in   = head_id;
               head_in     = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
               count_in    = count_ff - 1'b1;
            end
         end else begin
            // Enqueue the arrival or refuse it when the queue is full.
            if (count_ff == QCNT_W'(QUEUE_DEPTH)) begin
               refused_in = 1'b1;
            end else begin
               write_en = 1'b1;
               tail_in  = (tail_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         level_ff  <= level_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         strobe_ff <= cmd_link.valid;
      end
   end

   // Result payload and packet store need no reset.
   always_ff @(posedge clock) begin
      dropped_ff  <= dropped_in;
      released_ff <= released_in;
      rel_id_ff   <= rel_id_in;
      refused_ff  <= refused_in;
      if (write_en) begin
         store_ff[tail_ff] <= {cmd_link.cmd.packet_id, cmd_link.cmd.tokens_needed};
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_token_dropped   = dropped_ff;
   assign rsp_packet_released = released_ff;
   assign rsp_released_id     = rel_id_ff;
   assign rsp_packet_refused  = refused_ff;
   assign rsp_bucket_level    = level_ff;
   assign rsp_queue_count     = count_ff;

   // The waiting count never exceeds the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("packet queue overfilled");

   // Tail always leads head by the waiting count, modulo the depth.
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      tail_ff == QPTR_W'(head_ff + count_ff[QPTR_W-1:0]))
      else $error("packet queue pointers disagree with count");

   // A refusal never comes with a tick outcome.
   a_refuse_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !(rsp_packet_refused && (rsp_packet_released || rsp_token_dropped)))
      else $error("refusal mixed with tick result");

   // A release removes exactly one waiting packet.
   a_release_cnt: assert property (@(posedge clock) disable iff (reset)
      (cmd_link.valid && released_in) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("release did not lower the waiting count");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for token_bucket_packet_shaper_core: directed and random ticks
// and packet arrivals, each result checked against an in-bench model of bucket and queue.
// Depends on tbps_pkg and the shaper RTL.
module tb_top;
   import tbps_pkg::*;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned MAX_REPORTS = 10;
   localparam logic [CSR_ADDR_W-1:0] DEPTH_ADDR = CSR_ADDR_W'(4 * CSR_IDX_DEPTH);

   // One result as the shaper reports it.
   typedef struct packed {
      logic              token_dropped;
      logic              packet_released;
      logic [ID_W-1:0]   released_id;
      logic              packet_refused;
      logic [TOK_W-1:0]  bucket_level;
      logic [QCNT_W-1:0] queue_count;
   } shaper_result_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_operation;
   logic [ID_W-1:0]       req_packet_id;
   logic [TOK_W-1:0]      req_tokens_needed;
   logic                  rsp_strobe;
   logic                  rsp_token_dropped;
   logic                  rsp_packet_released;
   logic [ID_W-1:0]       rsp_released_id;
   logic                  rsp_packet_refused;
   logic [TOK_W-1:0]      rsp_bucket_level;
   logic [QCNT_W-1:0]     rsp_queue_count;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   // Shadow copy of the shaper state and its register.
   logic [TOK_W-1:0]       shaper_depth;
   logic [TOK_W-1:0]       bucket_tokens;
   logic [ID_W+TOK_W-1:0]  waiting_store [QUEUE_DEPTH];
   logic [QPTR_W-1:0]      queue_head;
   logic [QPTR_W-1:0]      queue_tail;
   logic [QCNT_W-1:0]      queue_fill;

   shaper_result_type shaped_results_q[$];
   int unsigned       error_count;
   int unsigned       stall_cycles;

   token_bucket_packet_shaper_core uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_operation       (req_operation),
      .req_packet_id       (req_packet_id),
      .req_tokens_needed   (req_tokens_needed),
      .rsp_strobe          (rsp_strobe),
      .rsp_token_dropped   (rsp_token_dropped),
      .rsp_packet_released (rsp_packet_released),
      .rsp_released_id     (rsp_released_id),
      .rsp_packet_refused  (rsp_packet_refused),
      .rsp_bucket_level    (rsp_bucket_level),
      .rsp_queue_count     (rsp_queue_count),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [QPTR_W-1:0] next_slot(logic [QPTR_W-1:0] slot);
      return (slot == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : slot + 1'b1;
   endfunction

   // Advances the shadow state by one tick or arrival and returns the expected result.
   function automatic shaper_result_type shape_step(logic op, logic [ID_W-1:0] id,
                                                    logic [TOK_W-1:0] need);
      shaper_result_type res;
      logic [TOK_W:0]    level_sum;
      logic [TOK_W-1:0]  head_need;
      res = '0;
      if (op == OP_TICK) begin
         // Add a token; drop it when the bucket would exceed its depth.
         level_sum = {1'b0, bucket_tokens} + 1'b1;
         if (level_sum > {1'b0, shaper_depth}) begin
            res.token_dropped = 1'b1;
            level_sum = level_sum - 1'b1;
         end
         bucket_tokens = level_sum[TOK_W-1:0];
         // Release the head packet if the bucket can pay for it.
         if (queue_fill != 0) begin
            head_need = waiting_store[queue_head][TOK_W-1:0];
            if (head_need <= bucket_tokens) begin
               bucket_tokens = bucket_tokens - head_need;
               res.packet_released = 1'b1;
               res.released_id = waiting_store[queue_head][ID_W+TOK_W-1:TOK_W];
               queue_head = next_slot(queue_head);
               queue_fill = queue_fill - 1'b1;
            end
         end
      end else begin
         if (queue_fill >= QUEUE_DEPTH) begin
            res.packet_refused = 1'b1;
         end else begin
            waiting_store[queue_tail] = {id, need};
            queue_tail = next_slot(queue_tail);
            queue_fill = queue_fill + 1'b1;
         end
      end
      res.bucket_level = bucket_tokens;
      res.queue_count = queue_fill;
      return res;
   endfunction

   task automatic flag_error(string msg);
      if (error_count < MAX_REPORTS) begin
         $display("ERROR at %0t: %s", $time, msg);
      end
      error_count++;
   endtask

   task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
      if (exp_val != got_val) begin
         flag_error($sformatf("%s expected 0x%0h, got 0x%0h", name, exp_val, got_val));
      end
   endtask

   // Each result strobe is matched against the oldest expected result.
   always @(posedge clock) begin : check_results
      shaper_result_type exp_r;
      if (!reset && rsp_strobe) begin
         if (shaped_results_q.size() == 0) begin
            flag_error("result strobe with no transfer outstanding");
         end else begin
            exp_r = shaped_results_q.pop_front();
            check_field("token_dropped", exp_r.token_dropped, rsp_token_dropped);
            check_field("packet_released", exp_r.packet_released, rsp_packet_released);
            check_field("released_id", exp_r.released_id, rsp_released_id);
            check_field("packet_refused", exp_r.packet_refused, rsp_packet_refused);
            check_field("bucket_level", exp_r.bucket_level, rsp_bucket_level);
            check_field("queue_count", exp_r.queue_count, rsp_queue_count);
         end
      end
   end

   // Ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Presents one item and waits for its transfer.
   task automatic send_item(logic op, logic [ID_W-1:0] id, logic [TOK_W-1:0] need);
      @(negedge clock);
      start <= 1'b1;
      req_operation <= op;
      req_packet_id <= id;
      req_tokens_needed <= need;
      @(posedge clock);
      while (busy) @(posedge clock);
      shaped_results_q.push_back(shape_step(op, id, need));
   endtask

   // A tick carries random values in the fields it ignores.
   task automatic send_tick();
      send_item(OP_TICK, ID_W'($urandom), TOK_W'($urandom));
   endtask

   task automatic pause_sender(int unsigned cycles);
      @(negedge clock);
      start <= 1'b0;
      req_operation <= 1'($urandom);
      req_packet_id <= ID_W'($urandom);
      req_tokens_needed <= TOK_W'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_results_done();
      @(negedge clock);
      start <= 1'b0;
      while (shaped_results_q.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic csr_read(logic [CSR_ADDR_W-1:0] addr, output logic [31:0] data);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      data = prdata;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Changes the depth once the shaper has finished all outstanding work.
   task automatic set_bucket_depth(logic [TOK_W-1:0] depth);
      logic [31:0] rd;
      wait_results_done();
      csr_write(DEPTH_ADDR, {16'($urandom), depth});
      shaper_depth = depth;
      csr_read(DEPTH_ADDR, rd);
      check_field("bucket_depth readback", depth, rd[TOK_W-1:0]);
   endtask

   task automatic test_reset_depth();
      logic [31:0] rd;
      csr_read(DEPTH_ADDR, rd);
      check_field("bucket_depth after reset", DEPTH_RESET, rd[TOK_W-1:0]);
   endtask

   task automatic test_basic_shaping();
      // A tick with all ones in the fields it ignores.
      send_item(OP_TICK, '1, '1);
      // A packet that needs no tokens leaves on the next tick.
      send_item(OP_ARRIVE, '1, '0);
      send_tick();
      send_item(OP_ARRIVE, '0, 16'd3);
      send_tick();
      // Fill the bucket past its depth so the last tokens are dropped.
      repeat (12) send_tick();
      // Overflow and release on the same tick.
      send_item(OP_ARRIVE, 16'h5A5A, 16'd10);
      send_tick();
   endtask

   task automatic test_queue_full();
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         send_item(OP_ARRIVE, ID_W'(16'hF000 + i), 16'd1);
      end
      // The queue is full, so these two are refused.
      send_item(OP_ARRIVE, 16'h0F0F, 16'd1);
      send_item(OP_ARRIVE, 16'hF0F0, 16'd1);
      // One packet leaves per tick until the queue is empty.
      repeat (QUEUE_DEPTH + 2) send_tick();
   endtask

   task automatic test_zero_depth();
      set_bucket_depth('0);
      // Every token is dropped; the level left over is kept.
      repeat (3) send_tick();
      send_item(OP_ARRIVE, 16'h00FF, '0);
      send_tick();
      send_item(OP_ARRIVE, 16'hFF00, 16'd1);
      send_tick();
   endtask

   task automatic test_bucket_saturation();
      // With the largest depth the bucket keeps every token.
      set_bucket_depth('1);
      repeat (40) send_tick();
      // Lowering the depth below the level keeps the level.
      set_bucket_depth(16'd5);
      repeat (2) send_tick();
      // A need equal to the whole level drains the bucket.
      send_item(OP_ARRIVE, 16'h1234, bucket_tokens);
      send_item(OP_ARRIVE, 16'h4321, '0);
      repeat (3) send_tick();
   endtask

   // Random mix of ticks and arrivals at one depth, with needs the depth can pay.
   task automatic run_random_phase(int unsigned count, logic [TOK_W-1:0] depth,
                                   int unsigned max_need, int unsigned arrive_pct,
                                   bit with_gaps);
      set_bucket_depth(depth);
      for (int i = 0; i < count; i++) begin
         // Idle bursts in part of every 64 items, none in the rest.
         if (with_gaps && (i % 64) < 40 && $urandom_range(0, 3) == 0) begin
            pause_sender($urandom_range(1, 14));
         end
         if (with_gaps && i == count / 2) begin
            wait_results_done();
         end
         if ($urandom_range(0, 99) < arrive_pct) begin
            send_item(OP_ARRIVE, ID_W'($urandom), TOK_W'($urandom_range(0, max_need)));
         end else begin
            send_tick();
         end
      end
      // Empty the queue so no packet is stranded by the next depth.
      while (queue_fill != 0) send_tick();
   endtask

   initial begin
      logic [TOK_W-1:0] rand_depth;
      start <= 1'b0;
      req_operation <= OP_TICK;
      req_packet_id <= '0;
      req_tokens_needed <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      error_count = 0;
      shaper_depth = DEPTH_RESET;
      bucket_tokens = '0;
      queue_head = '0;
      queue_tail = '0;
      queue_fill = '0;
      reset <= 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_depth();
      test_basic_shaping();
      test_queue_full();
      test_zero_depth();
      test_bucket_saturation();

      run_random_phase(160, 16'd1, 1, 50, 1'b1);
      run_random_phase(160, DEPTH_RESET, 10, 30, 1'b1);
      run_random_phase(160, '1, 8, 45, 1'b1);
      run_random_phase(160, 16'd3, 3, 35, 1'b1);
      rand_depth = TOK_W'($urandom_range(2, 16));
      run_random_phase(160, rand_depth, rand_depth, 35, 1'b1);
      // Closing stretch with the sender never idle.
      run_random_phase(120, 16'd7, 7, 40, 1'b0);

      wait_results_done();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
